// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL; every use sits inside a module with clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check, sampled on the rising edge, off while reset is held.
`define BDM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bdm: assertion failed");

// Implication in the same cycle.
`define BDM_ASSERT_IMP(label, ante, cons) `BDM_ASSERT(label, (ante) |-> (cons))

`endif

// ----- hdl/bdm_pkg.sv -----
// ----------------------------------------------------------------------------
// bdm_pkg
// Types, register codes and arithmetic helpers of the Bayer demosaic block.
// ----------------------------------------------------------------------------
package bdm_pkg;

  localparam int MaxWidthDef  = 4096;
  localparam int MaxHeightDef = 4096;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 13;
  localparam int FifoDepth    = 8;
  localparam int LaneN        = 8;   // line stores kept per column word

  typedef enum logic [CfgIdxW-1:0] {
    REG_ALGORITHM = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_SOURCE    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SRC_RED   = 2'd0,
    SRC_GREEN = 2'd1,
    SRC_BLUE  = 2'd2,
    SRC_ALT   = 2'd3
  } src_chan_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_item_t;

  // widen a sample for the kernel sums
  function automatic logic signed [15:0] sx(input logic [7:0] b);
    return signed'(16'(b));
  endfunction

  // round half up of num / 2^sh, clamp to 0..255
  function automatic logic [7:0] rnd(input logic signed [15:0] num, input logic [2:0] sh);
    logic signed [15:0] v;
    v = num + (16'sd1 <<< (sh - 3'd1));
    if (v < 16'sd0) begin
      return 8'd0;
    end
    v = v >>> sh;
    if (v > 16'sd255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

endpackage

// ----- hdl/bayer_demosaic_bilinear_mhc.sv -----
// ----------------------------------------------------------------------------
// bayer_demosaic_bilinear_mhc
// Streaming RGGB demosaic, bilinear or Malvar-He-Cutler, one pixel per clock.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_item_i): one raster sample per
// transaction, or a drain tick (mode = 1). Output channel (out_valid_o /
// out_stall_i / out_item_o): one RGB pixel per transaction, frame_end on the
// last pixel of the frame. Output runs 2*W+2 pixels behind the input; after
// the whole frame is in, drain ticks push out the remaining pixels.
// Throughput: one transaction per clock on both sides while neither side
// stalls. An emitting input transaction passes through the input register,
// counters and address folding, line store read, window select, and kernel
// math into an 8-entry output queue, which drives out_valid_o.
// The line stores are three copies of a MAX_WIDTH x 64-bit memory (one byte
// lane per line); the first two have two read ports and the third has one, so
// the five window columns are read in the same cycle.
// The user makes configuration writes (cfg_valid_i, always ready) only while
// idle, which the block leaves unchecked; writing width or height restarts
// the frame. Reset clears counters, queue and registers (algorithm 0, width
// 4096, height 4096, source red). When the receiver stalls, results collect
// in the queue; in_stall_o rises only when queue plus pipeline could overflow.
module bayer_demosaic_bilinear_mhc
  import bdm_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int WDimW  = $clog2(MAX_WIDTH + 1);
  localparam int RowW   = $clog2(MAX_HEIGHT + 1);
  localparam int LeadW  = $clog2(2 * MAX_WIDTH + 4);
  localparam int MaxDim = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int PosW   = $clog2(MaxDim + 1) + 3;
  localparam int WordW  = LaneN * 8;
  localparam int CntW   = $clog2(FifoDepth + 1);
  localparam int PtrW   = $clog2(FifoDepth);
  localparam int SumW   = CntW + 3;

  // ---------------- configuration ----------------
  logic                alg_q;
  logic [CfgDataW-1:0] cfg_w_q, cfg_h_q;
  logic [1:0]          src_q;
  logic                cfg_restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_restart = cfg_valid_i && (cfg_reg_e'(cfg_index_i) == REG_WIDTH ||
                                       cfg_reg_e'(cfg_index_i) == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q   <= 1'b0;
      cfg_w_q <= CfgDataW'(4096);
      cfg_h_q <= CfgDataW'(4096);
      src_q   <= 2'(SRC_RED);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ALGORITHM: alg_q   <= cfg_data_i[0];
        REG_WIDTH:     cfg_w_q <= cfg_data_i;
        REG_HEIGHT:    cfg_h_q <= cfg_data_i;
        REG_SOURCE:    src_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [WDimW-1:0] w_eff;
  logic [RowW-1:0]  h_eff;
  logic [LeadW-1:0] thresh;

  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = WDimW'(1);
    end else if (int'(cfg_w_q) > MAX_WIDTH) begin
      w_eff = WDimW'(MAX_WIDTH);
    end else begin
      w_eff = WDimW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = RowW'(1);
    end else if (int'(cfg_h_q) > MAX_HEIGHT) begin
      h_eff = RowW'(MAX_HEIGHT);
    end else begin
      h_eff = RowW'(cfg_h_q);
    end
    thresh = LeadW'({w_eff, 1'b0}) + LeadW'(3);
  end

  // ---------------- stage A: input register ----------------
  logic     a_valid_q;
  in_item_t a_item_q;
  logic     in_stall_q;

  assign in_stall_o = in_stall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_valid_i && !in_stall_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_q) begin
      a_item_q <= in_item_i;
    end
  end

  // ---------------- stage B: counters, write, emit ----------------
  logic [ColW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [LeadW-1:0] lead_q, lead_d;
  logic             done_now, wr_en, emit, last;
  logic [7:0]       wr_byte;

  always_comb begin
    unique case (src_chan_e'(src_q))
      SRC_RED:   wr_byte = a_item_q.in_red;
      SRC_GREEN: wr_byte = a_item_q.in_green;
      default:   wr_byte = a_item_q.in_blue;
    endcase
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lead_d    = lead_q;
    wr_en     = 1'b0;
    emit      = 1'b0;
    last      = 1'b0;
    done_now  = in_row_q >= h_eff;
    if (a_valid_q) begin
      if (!a_item_q.mode && !done_now) begin
        wr_en = 1'b1;
        if (int'(in_col_q) + 1 >= int'(w_eff)) begin
          in_col_d = '0;
          in_row_d = in_row_q + RowW'(1);
        end else begin
          in_col_d = in_col_q + ColW'(1);
        end
        emit   = (in_row_d >= h_eff) || (lead_q + LeadW'(1) >= thresh);
        lead_d = emit ? lead_q : lead_q + LeadW'(1);
      end else begin
        emit = done_now;
      end
      if (emit) begin
        if (int'(out_col_q) + 1 >= int'(w_eff)) begin
          out_col_d = '0;
          out_row_d = out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
        if (out_row_d >= h_eff) begin
          // last pixel out: start the next frame
          last      = 1'b1;
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
          lead_d    = '0;
        end
      end
    end
    if (cfg_restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      lead_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lead_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lead_q    <= lead_d;
    end
  end

  // border folding: mirror (if asked), then clamp
  function automatic logic signed [PosW-1:0] fold(input logic signed [PosW-1:0] p,
                                                  input logic signed [PosW-1:0] size,
                                                  input logic mirror);
    logic signed [PosW-1:0] q;
    q = p;
    if (mirror) begin
      if (q < 0) begin
        q = -q;
      end else if (q >= size) begin
        q = (size <<< 1) - q - signed'(PosW'(2));
      end
    end
    if (q > size - signed'(PosW'(1))) begin
      q = size - signed'(PosW'(1));
    end
    if (q < 0) begin
      q = '0;
    end
    return q;
  endfunction

  logic [ColW-1:0] col_addr_d [5];
  logic [2:0]      row_lane_d [5];
  logic signed [PosW-1:0] fc, fr;

  always_comb begin
    for (int d = 0; d < 5; d++) begin
      fc = fold(signed'(PosW'(out_col_q)) + PosW'(d - 2), signed'(PosW'(w_eff)), alg_q);
      fr = fold(signed'(PosW'(out_row_q)) + PosW'(d - 2), signed'(PosW'(h_eff)), alg_q);
      col_addr_d[d] = fc[ColW-1:0];
      row_lane_d[d] = fr[2:0];
    end
  end

  // ---------------- stage C: addresses ----------------
  logic            c_valid_q, c_er_q, c_ec_q, c_alg_q, c_last_q;
  logic [ColW-1:0] c_col_q  [5];
  logic [2:0]      c_lane_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    c_col_q  <= col_addr_d;
    c_lane_q <= row_lane_d;
    c_er_q   <= ~out_row_q[0];
    c_ec_q   <= ~out_col_q[0];
    c_alg_q  <= alg_q;
    c_last_q <= last;
  end

  // ---------------- line stores ----------------
  logic [WordW-1:0] mem_a [MAX_WIDTH];
  logic [WordW-1:0] mem_b [MAX_WIDTH];
  logic [WordW-1:0] mem_c [MAX_WIDTH];
  logic [WordW-1:0] rd_q  [5];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a[in_col_q][{in_row_q[2:0], 3'b000} +: 8] <= wr_byte;
      mem_b[in_col_q][{in_row_q[2:0], 3'b000} +: 8] <= wr_byte;
      mem_c[in_col_q][{in_row_q[2:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_q[0] <= mem_a[c_col_q[0]];
    rd_q[1] <= mem_a[c_col_q[1]];
    rd_q[2] <= mem_b[c_col_q[2]];
    rd_q[3] <= mem_b[c_col_q[3]];
    rd_q[4] <= mem_c[c_col_q[4]];
  end

  // ---------------- stage D: column words ----------------
  logic       d_valid_q, d_er_q, d_ec_q, d_alg_q, d_last_q;
  logic [2:0] d_lane_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_lane_q <= c_lane_q;
    d_er_q   <= c_er_q;
    d_ec_q   <= c_ec_q;
    d_alg_q  <= c_alg_q;
    d_last_q <= c_last_q;
  end

  // pick the window sample of one row lane from a column word
  function automatic logic [7:0] tap(input logic [WordW-1:0] word, input logic [2:0] lane);
    return word[{lane, 3'b000} +: 8];
  endfunction

  // ---------------- stage E: window taps ----------------
  logic       e_valid_q, e_er_q, e_ec_q, e_alg_q, e_last_q;
  logic [7:0] e_c, e_n, e_s, e_w, e_e, e_nw, e_ne, e_sw, e_se, e_n2, e_s2, e_w2, e_e2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_c      <= tap(rd_q[2], d_lane_q[2]);
    e_n      <= tap(rd_q[2], d_lane_q[1]);
    e_s      <= tap(rd_q[2], d_lane_q[3]);
    e_w      <= tap(rd_q[1], d_lane_q[2]);
    e_e      <= tap(rd_q[3], d_lane_q[2]);
    e_nw     <= tap(rd_q[1], d_lane_q[1]);
    e_ne     <= tap(rd_q[3], d_lane_q[1]);
    e_sw     <= tap(rd_q[1], d_lane_q[3]);
    e_se     <= tap(rd_q[3], d_lane_q[3]);
    e_n2     <= tap(rd_q[2], d_lane_q[0]);
    e_s2     <= tap(rd_q[2], d_lane_q[4]);
    e_w2     <= tap(rd_q[0], d_lane_q[2]);
    e_e2     <= tap(rd_q[4], d_lane_q[2]);
    e_er_q   <= d_er_q;
    e_ec_q   <= d_ec_q;
    e_alg_q  <= d_alg_q;
    e_last_q <= d_last_q;
  end

  // ---------------- kernels ----------------
  logic signed [15:0] s_ns, s_we, s_diag, s_nsf, s_wef, s_far, s_gx, s_dx, s_hz, s_vt;
  out_item_t          res;

  always_comb begin
    s_ns   = sx(e_n) + sx(e_s);
    s_we   = sx(e_w) + sx(e_e);
    s_diag = sx(e_nw) + sx(e_ne) + sx(e_sw) + sx(e_se);
    s_nsf  = sx(e_n2) + sx(e_s2);
    s_wef  = sx(e_w2) + sx(e_e2);
    s_far  = s_nsf + s_wef;
    s_gx   = (sx(e_c) <<< 2) + ((s_ns + s_we) <<< 1) - s_far;
    s_dx   = 16'sd12 * sx(e_c) + (s_diag <<< 2) - 16'sd3 * s_far;
    s_hz   = 16'sd10 * sx(e_c) + (s_we <<< 3) - (s_wef <<< 1) - (s_diag <<< 1) + s_nsf;
    s_vt   = 16'sd10 * sx(e_c) + (s_ns <<< 3) - (s_nsf <<< 1) - (s_diag <<< 1) + s_wef;
    res.frame_end = e_last_q;
    if (!e_alg_q) begin
      priority if (e_er_q && e_ec_q) begin
        res.out_red   = e_c;
        res.out_green = rnd(s_ns + s_we, 3'd2);
        res.out_blue  = rnd(s_diag, 3'd2);
      end else if (e_er_q) begin
        res.out_red   = rnd(s_we, 3'd1);
        res.out_green = e_c;
        res.out_blue  = rnd(s_ns, 3'd1);
      end else if (e_ec_q) begin
        res.out_red   = rnd(s_ns, 3'd1);
        res.out_green = e_c;
        res.out_blue  = rnd(s_we, 3'd1);
      end else begin
        res.out_red   = rnd(s_diag, 3'd2);
        res.out_green = rnd(s_ns + s_we, 3'd2);
        res.out_blue  = e_c;
      end
    end else begin
      priority if (e_er_q && e_ec_q) begin
        res.out_red   = e_c;
        res.out_green = rnd(s_gx, 3'd3);
        res.out_blue  = rnd(s_dx, 3'd4);
      end else if (e_er_q) begin
        res.out_red   = rnd(s_hz, 3'd4);
        res.out_green = e_c;
        res.out_blue  = rnd(s_vt, 3'd4);
      end else if (e_ec_q) begin
        res.out_red   = rnd(s_vt, 3'd4);
        res.out_green = e_c;
        res.out_blue  = rnd(s_hz, 3'd4);
      end else begin
        res.out_red   = rnd(s_dx, 3'd4);
        res.out_green = rnd(s_gx, 3'd3);
        res.out_blue  = e_c;
      end
    end
  end

  // ---------------- output queue ----------------
  out_item_t       fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;
  logic [SumW-1:0] pending_d;

  assign push        = e_valid_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = fifo_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
    pending_d = SumW'(cnt_d) + SumW'(in_valid_i && !in_stall_q) + SumW'(a_valid_q)
              + SumW'(c_valid_q) + SumW'(d_valid_q) + SumW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      in_stall_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
      // hold off input when every in-flight item plus one more could not fit
      in_stall_q <= pending_d > SumW'(FifoDepth);
    end
  end

  // ---------------- checks ----------------
  `include "assert_macros.svh"

  `BDM_ASSERT(a_fifo_bound, cnt_q <= CntW'(FifoDepth))
  `BDM_ASSERT_IMP(a_no_overflow, push && !pop, cnt_q < CntW'(FifoDepth))
  `BDM_ASSERT(a_lead_bound, lead_q < thresh || in_row_q >= h_eff)
  `BDM_ASSERT_IMP(a_write_in_frame, wr_en, !a_item_q.mode && in_row_q < h_eff)

endmodule
